// File: design/cfd_pkg.sv
`default_nettype none
package cfd_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       connection_restart;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  event_kind;
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic        pressed;
    } t_out_item;

    // command tags, first received byte in the top byte
    localparam logic [31:0] TAG_GIMG = 32'h47494D47;
    localparam logic [31:0] TAG_TLRD = 32'h544C5244;
    localparam logic [31:0] TAG_CHDP = 32'h43484450;
    localparam logic [31:0] TAG_SCUP = 32'h53435550;
    localparam logic [31:0] TAG_SCUD = 32'h53435544;
    localparam logic [31:0] TAG_SKST = 32'h534B5354;
    localparam logic [31:0] TAG_SMKS = 32'h534D4B53;
    localparam logic [31:0] TAG_SMWH = 32'h534D5748;
    localparam logic [31:0] TAG_SARQ = 32'h53415251;

    localparam logic [3:0] EV_START_CAPTURE  = 4'd0;
    localparam logic [3:0] EV_TILE_ACK       = 4'd1;
    localparam logic [3:0] EV_CHANGE_DISPLAY = 4'd2;
    localparam logic [3:0] EV_CURSOR_POS     = 4'd3;
    localparam logic [3:0] EV_CURSOR_DELTA   = 4'd4;
    localparam logic [3:0] EV_KEY            = 4'd5;
    localparam logic [3:0] EV_MOUSE_BUTTON   = 4'd6;
    localparam logic [3:0] EV_WHEEL          = 4'd7;
    localparam logic [3:0] EV_AUTH_REQUEST   = 4'd8;

    localparam logic [15:0] MIN_WORD_PAYLOAD = 16'd4;
    localparam logic [15:0] MIN_TILE_PAYLOAD = 16'd2;
    localparam logic [15:0] TAG_BYTES        = 16'd4;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic        REG_SESSION_AUTH = 1'b0;

endpackage
`default_nettype wire

// File: design/cfd_in_if.sv
`default_nettype none
interface cfd_in_if;
    import cfd_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/cfd_out_if.sv
`default_nettype none
interface cfd_out_if;
    import cfd_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: design/command_frame_deframer_top.sv
// Command frame deframer.
// i_in carries one received byte per item, with a restart flag that clears the
// parser before the byte is taken. Frames are a 4-byte ASCII tag, a 16-bit
// little-endian length and the payload; the first four payload bytes are kept
// as two little-endian words. o_out carries at most one input event per frame,
// given on the item that carries the frame's last byte.
// Throughput: one byte per cycle while i_in.ready is high. Each byte updates the
// parser registers and the decoded event is registered, so the event is valid in
// the cycle after the last byte of its frame is accepted.
// A single output register holds the event; i_in.ready stays high while it is
// empty or being taken, so a stalled receiver stalls input only when an event
// is waiting.
// The APB port holds the session_authenticated register at address 0; while it
// is 0 only the auth request tag produces an event.
// Reset (synchronous, active low) clears the parser, the output valid flag and
// the session flag.
`default_nettype none
module command_frame_deframer_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    cfd_in_if.sink                        i_in,
    cfd_out_if.source                     o_out,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [cfd_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire [31:0]                    pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import cfd_pkg::*;

    localparam logic [1:0] PH_TAG = 2'd0;
    localparam logic [1:0] PH_LEN = 2'd1;
    localparam logic [1:0] PH_PAY = 2'd2;

    logic        r_auth;
    logic [1:0]  r_phase, c_phase, n_phase;
    logic [31:0] r_tag, c_tag, n_tag;
    logic [15:0] r_count, c_count, n_count;
    logic [15:0] r_len, c_len, n_len;
    logic [15:0] r_wlo, c_wlo, n_wlo;
    logic [15:0] r_whi, c_whi, n_whi;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        accept;
    logic        frame_end;
    logic        hit;
    logic        full;
    t_out_item   result;
    logic [7:0]  b;

    assign pready = 1'b1;
    assign prdata = {31'd0, r_auth};

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign b           = i_in.data.rx_byte;

    // next parser state for the byte on the input
    always_comb begin
        if (i_in.data.connection_restart) begin
            c_phase = PH_TAG;
            c_tag   = '0;
            c_count = '0;
            c_len   = '0;
            c_wlo   = '0;
            c_whi   = '0;
        end else begin
            c_phase = r_phase;
            c_tag   = r_tag;
            c_count = r_count;
            c_len   = r_len;
            c_wlo   = r_wlo;
            c_whi   = r_whi;
        end
        n_phase   = c_phase;
        n_tag     = c_tag;
        n_count   = c_count;
        n_len     = c_len;
        n_wlo     = c_wlo;
        n_whi     = c_whi;
        frame_end = 1'b0;
        unique case (c_phase)
            PH_LEN: begin
                if (c_count == 16'd0) begin
                    n_len   = {8'd0, b};
                    n_count = 16'd1;
                end else begin
                    n_len   = {b, c_len[7:0]};
                    n_count = 16'd0;
                    n_wlo   = 16'd0;
                    n_whi   = 16'd0;
                    if (n_len == 16'd0) begin
                        frame_end = 1'b1;
                        n_phase   = PH_TAG;
                        n_tag     = '0;
                    end else begin
                        n_phase = PH_PAY;
                    end
                end
            end
            PH_PAY: begin
                case (c_count)
                    16'd0:   n_wlo = {8'd0, b};
                    16'd1:   n_wlo = c_wlo | {b, 8'd0};
                    16'd2:   n_whi = {8'd0, b};
                    16'd3:   n_whi = c_whi | {b, 8'd0};
                    default: ;
                endcase
                n_count = c_count + 16'd1;
                if (n_count == c_len) begin
                    frame_end = 1'b1;
                    n_phase   = PH_TAG;
                    n_tag     = '0;
                    n_count   = 16'd0;
                end
            end
            default: begin
                // unused phase code behaves as tag collection
                n_phase = PH_TAG;
                n_tag   = {c_tag[23:0], b};
                n_count = c_count + 16'd1;
                if (n_count >= TAG_BYTES) begin
                    n_phase = PH_LEN;
                    n_count = 16'd0;
                end
            end
        endcase
    end

    // tag decode on the frame's final byte
    always_comb begin
        full   = n_len >= MIN_WORD_PAYLOAD;
        hit    = 1'b0;
        result = '0;
        if (c_tag == TAG_SARQ) begin
            hit               = 1'b1;
            result.event_kind = EV_AUTH_REQUEST;
        end else if (r_auth) begin
            unique case (c_tag) inside
                TAG_GIMG: begin
                    hit               = 1'b1;
                    result.event_kind = EV_START_CAPTURE;
                end
                TAG_TLRD: begin
                    hit               = 1'b1;
                    result.event_kind = EV_TILE_ACK;
                    result.first_word = (n_len >= MIN_TILE_PAYLOAD) ? n_wlo : 16'd0;
                end
                TAG_CHDP: begin
                    hit               = 1'b1;
                    result.event_kind = EV_CHANGE_DISPLAY;
                end
                TAG_SCUP, TAG_SCUD: begin
                    hit                = full;
                    result.event_kind  = (c_tag == TAG_SCUP) ? EV_CURSOR_POS
                                                             : EV_CURSOR_DELTA;
                    result.first_word  = n_wlo;
                    result.second_word = n_whi;
                end
                TAG_SKST, TAG_SMKS: begin
                    hit                = full;
                    result.event_kind  = (c_tag == TAG_SKST) ? EV_KEY : EV_MOUSE_BUTTON;
                    result.first_word  = n_wlo;
                    result.second_word = n_whi;
                    result.pressed     = n_whi != 16'd0;
                end
                TAG_SMWH: begin
                    hit                = full;
                    result.event_kind  = EV_WHEEL;
                    result.second_word = n_whi;
                    result.pressed     = n_whi != 16'd0;
                end
                default: hit = 1'b0;
            endcase
        end
        hit = hit && frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auth      <= 1'b0;
            r_phase     <= PH_TAG;
            r_tag       <= '0;
            r_count     <= '0;
            r_len       <= '0;
            r_wlo       <= '0;
            r_whi       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == REG_SESSION_AUTH) begin
                r_auth <= pwdata[0];
            end
            if (accept) begin
                r_phase     <= n_phase;
                r_tag       <= n_tag;
                r_count     <= n_count;
                r_len       <= n_len;
                r_wlo       <= n_wlo;
                r_whi       <= n_whi;
                r_out_valid <= hit;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && hit) begin
            r_out <= result;
        end
    end

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cfd_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned WHOLE_FRAME  = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        COLLECT_TAG,
        COLLECT_LENGTH,
        COLLECT_PAYLOAD
    } t_frame_phase;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    wire  [31:0]           prdata;
    wire                   pready;

    cfd_in_if  in_if ();
    cfd_out_if out_if ();

    command_frame_deframer_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // bytes waiting to be sent, events waiting to be seen
    t_in_item    rx_backlog[$];
    t_out_item   pending_events[$];
    int unsigned queued_total;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatch_count;
    int unsigned quiet_cycles;

    // parser state as the block should hold it
    t_frame_phase frame_phase;
    logic [31:0]  tag_bits;
    logic [15:0]  byte_idx;
    logic [15:0]  payload_len;
    logic [15:0]  word_lo;
    logic [15:0]  word_hi;
    logic         auth_enabled;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void clear_parser();
        frame_phase = COLLECT_TAG;
        tag_bits    = '0;
        byte_idx    = '0;
        payload_len = '0;
        word_lo     = '0;
        word_hi     = '0;
    endfunction

    function automatic logic decode_frame_event(output t_out_item ev);
        ev = '0;
        if (tag_bits == TAG_SARQ) begin
            ev.event_kind = EV_AUTH_REQUEST;
            return 1'b1;
        end
        if (!auth_enabled) return 1'b0;
        case (tag_bits)
            TAG_GIMG: ev.event_kind = EV_START_CAPTURE;
            TAG_CHDP: ev.event_kind = EV_CHANGE_DISPLAY;
            TAG_TLRD: begin
                ev.event_kind = EV_TILE_ACK;
                if (payload_len >= MIN_TILE_PAYLOAD) ev.first_word = word_lo;
            end
            TAG_SCUP, TAG_SCUD: begin
                ev.event_kind  = (tag_bits == TAG_SCUP) ? EV_CURSOR_POS : EV_CURSOR_DELTA;
                ev.first_word  = word_lo;
                ev.second_word = word_hi;
            end
            TAG_SKST, TAG_SMKS: begin
                ev.event_kind  = (tag_bits == TAG_SKST) ? EV_KEY : EV_MOUSE_BUTTON;
                ev.first_word  = word_lo;
                ev.second_word = word_hi;
                ev.pressed     = |word_hi;
            end
            TAG_SMWH: begin
                ev.event_kind  = EV_WHEEL;
                ev.second_word = word_hi;
                ev.pressed     = |word_hi;
            end
            default: return 1'b0;
        endcase
        // pointer, key, button and wheel need both words
        if (payload_len < MIN_WORD_PAYLOAD && ev.event_kind >= EV_CURSOR_POS) return 1'b0;
        return 1'b1;
    endfunction

    task automatic take_byte(input t_in_item item);
        t_out_item  ev;
        logic       fire;
        logic [7:0] b;
        fire = 1'b0;
        b    = item.rx_byte;
        if (item.connection_restart) clear_parser();
        case (frame_phase)
            COLLECT_LENGTH: begin
                if (byte_idx == 16'd0) begin
                    payload_len = {8'h00, b};
                    byte_idx    = 16'd1;
                end else begin
                    payload_len = {b, payload_len[7:0]};
                    byte_idx    = '0;
                    word_lo     = '0;
                    word_hi     = '0;
                    if (payload_len == 16'd0) begin
                        fire        = decode_frame_event(ev);
                        frame_phase = COLLECT_TAG;
                        tag_bits    = '0;
                    end else begin
                        frame_phase = COLLECT_PAYLOAD;
                    end
                end
            end
            COLLECT_PAYLOAD: begin
                case (byte_idx)
                    16'd0: word_lo = {8'h00, b};
                    16'd1: word_lo[15:8] = b;
                    16'd2: word_hi = {8'h00, b};
                    16'd3: word_hi[15:8] = b;
                    default: ;
                endcase
                byte_idx = byte_idx + 16'd1;
                if (byte_idx == payload_len) begin
                    fire        = decode_frame_event(ev);
                    frame_phase = COLLECT_TAG;
                    tag_bits    = '0;
                    byte_idx    = '0;
                end
            end
            default: begin
                frame_phase = COLLECT_TAG;
                tag_bits    = {tag_bits[23:0], b};
                byte_idx    = byte_idx + 16'd1;
                if (byte_idx >= TAG_BYTES) begin
                    frame_phase = COLLECT_LENGTH;
                    byte_idx    = '0;
                end
            end
        endcase
        if (fire) pending_events.push_back(ev);
    endtask

    task automatic report_mismatch(input string what, input t_out_item want,
                                   input t_out_item got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $write("%s: expected kind %0d first %h second %h pressed %b, ",
                   what, want.event_kind, want.first_word, want.second_word, want.pressed);
            $display("got kind %0d first %h second %h pressed %b",
                     got.event_kind, got.first_word, got.second_word, got.pressed);
        end
    endtask

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                take_byte(in_if.data);
            end
            if (!in_if.valid || in_if.ready) begin
                if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_if.valid <= 1'b1;
                    in_if.data  <= rx_backlog.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // event monitor
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = out_if.data;
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected event", '0, got);
            end else begin
                want = pending_events.pop_front();
                if (got.event_kind !== want.event_kind || got.first_word !== want.first_word
                    || got.second_word !== want.second_word || got.pressed !== want.pressed) begin
                    report_mismatch("event mismatch", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("testbench failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic write_register(input int unsigned index, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * index);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_SESSION_AUTH) auth_enabled = value[0];
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic restart);
        t_in_item item;
        item.rx_byte            = b;
        item.connection_restart = restart;
        rx_backlog.push_back(item);
        queued_total++;
    endtask

    // head holds payload bytes 0..3, byte 0 in the low bits; only the first cut bytes go out
    task automatic queue_frame(input logic [31:0] tag, input int unsigned len,
                               input logic [31:0] head, input int unsigned cut,
                               input logic restart);
        logic [15:0] len16;
        logic [7:0]  b;
        len16 = len[15:0];
        for (int unsigned k = 0; k < 6 + len && k < cut; k++) begin
            if (k < 4)       b = tag[31 - 8 * k -: 8];
            else if (k == 4) b = len16[7:0];
            else if (k == 5) b = len16[15:8];
            else if (k < 10) b = head[8 * (k - 6) +: 8];
            else             b = 8'($urandom_range(255));
            queue_byte(b, restart && k == 0);
        end
    endtask

    function automatic logic [31:0] random_tag();
        int unsigned r;
        logic [31:0] t;
        r = $urandom_range(99);
        if (r < 20) return TAG_SARQ;
        if (r >= 88) begin
            // near misses as well as plain noise
            t = $urandom();
            if (r < 94) begin
                t = TAG_SKST;
                t[8 * $urandom_range(3) +: 8] = 8'($urandom_range(255));
            end
            return t;
        end
        case ($urandom_range(7))
            0: return TAG_GIMG;
            1: return TAG_TLRD;
            2: return TAG_CHDP;
            3: return TAG_SCUP;
            4: return TAG_SCUD;
            5: return TAG_SKST;
            6: return TAG_SMKS;
            default: return TAG_SMWH;
        endcase
    endfunction

    function automatic int unsigned random_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return 0;
        if (r < 70) return $urandom_range(1, 6);
        if (r < 96) return $urandom_range(7, 24);
        return $urandom_range(200, 300);
    endfunction

    function automatic logic [31:0] random_head();
        logic [31:0] h;
        h = $urandom();
        if ($urandom_range(3) == 0) h[31:16] = '0;
        return h;
    endfunction

    task automatic queue_random_traffic(input int unsigned n_items);
        int unsigned start;
        int unsigned len;
        int unsigned r;
        logic        restart_next;
        start        = queued_total;
        restart_next = 1'b0;
        @(negedge i_clk);
        while (queued_total - start < n_items) begin
            r   = $urandom_range(99);
            len = random_length();
            if (r < 80) begin
                queue_frame(random_tag(), len, random_head(), WHOLE_FRAME,
                            restart_next || $urandom_range(9) == 0);
                restart_next = 1'b0;
            end else if (r < 90) begin
                // frame broken off, the next one resyncs with a restart
                queue_frame(random_tag(), len, random_head(), $urandom_range(1, 5 + len),
                            restart_next);
                restart_next = 1'b1;
            end else begin
                repeat ($urandom_range(1, 6))
                    queue_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
                restart_next = 1'b1;
            end
        end
    endtask

    task automatic wait_until_drained();
        @(negedge i_clk);
        while (rx_backlog.size() != 0 || in_if.valid || pending_events.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_if.valid    = 1'b0;
        in_if.data     = '0;
        out_if.ready   = 1'b0;
        queued_total   = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        auth_enabled   = 1'b0;
        clear_parser();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // not logged in: only the auth request gets through
        write_register(REG_SESSION_AUTH, 32'd0);
        @(negedge i_clk);
        queue_frame(TAG_SARQ, 0, 32'h0, WHOLE_FRAME, 1'b0);
        queue_frame(TAG_GIMG, 0, 32'h0, WHOLE_FRAME, 1'b0);
        queue_frame(TAG_SARQ, 2, 32'h0000_FFFF, WHOLE_FRAME, 1'b0);
        wait_until_drained();

        write_register(REG_SESSION_AUTH, 32'd1);
        @(negedge i_clk);
        queue_frame(TAG_GIMG, 0, 32'h0, WHOLE_FRAME, 1'b1);
        queue_frame(TAG_TLRD, 1, 32'h0000_00FF, WHOLE_FRAME, 1'b0);
        queue_frame(TAG_TLRD, 2, 32'h0000_FFFF, WHOLE_FRAME, 1'b0);
        queue_frame(TAG_CHDP, 1, 32'h0, WHOLE_FRAME, 1'b0);
        queue_frame(TAG_SCUP, 4, 32'h0000_FFFF, WHOLE_FRAME, 1'b0);
        queue_frame(TAG_SCUD, 5, 32'hFFFF_8000, WHOLE_FRAME, 1'b0);
        queue_frame(TAG_SKST, 4, 32'h0000_0041, WHOLE_FRAME, 1'b0);
        queue_frame(TAG_SMKS, 3, 32'h00FF_0001, WHOLE_FRAME, 1'b0);
        queue_frame(TAG_SMKS, 4, 32'h0001_0001, WHOLE_FRAME, 1'b0);
        queue_frame(TAG_SMWH, 4, 32'hFF88_1234, WHOLE_FRAME, 1'b0);
        queue_frame(TAG_SKST, 0, 32'h0, WHOLE_FRAME, 1'b0);
        queue_frame(32'hFFFF_FFFF, 1, 32'h0, WHOLE_FRAME, 1'b0);
        queue_frame(32'h0000_0000, 0, 32'h0, WHOLE_FRAME, 1'b0);
        // maximum length abandoned part way, then restarts mid-length and mid-tag
        queue_frame(TAG_SCUP, 32'hFFFF, 32'hFFFF_FFFF, 8, 1'b0);
        queue_frame(TAG_CHDP, 0, 32'h0, 5, 1'b1);
        queue_frame(TAG_SKST, 0, 32'h0, 2, 1'b1);
        queue_frame(TAG_SARQ, 0, 32'h0, WHOLE_FRAME, 1'b1);
        wait_until_drained();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            write_register(REG_SESSION_AUTH, (p == 1) ? 32'd0 : 32'd1);
            queue_random_traffic(100);
            wait_until_drained();
        end

        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
